FILE: rtl/core/clock_tree_frequency_readback_assert.svh
`ifndef CLOCK_TREE_FREQUENCY_READBACK_ASSERT_SVH
`define CLOCK_TREE_FREQUENCY_READBACK_ASSERT_SVH

// check cons in the same cycle as ante
`define CTFR_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// check cons in the cycle after ante
`define CTFR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/core/ctfr_pkg.sv
package ctfr_pkg;

   localparam logic [24:0] XTAL_HZ = 25'd24000000;
   localparam logic [14:0] LOSC_HZ = 15'd32000;
   localparam logic [63:0] RECIP3  = 64'h0000_0000_AAAA_AAAB;
   localparam int          NCELLS  = 5;

   typedef enum logic [1:0] {
      SRC_LOSC   = 2'd0,
      SRC_XTAL   = 2'd1,
      SRC_CPU    = 2'd2,
      SRC_PERIPH = 2'd3
   } src_type;

   typedef struct packed {
      logic [31:0] cpu;
      logic [29:0] per;
      logic [29:0] per_pre;
      logic [31:0] apb;
      logic [2:0]  kp1;
      logic [1:0]  m;
      logic [1:0]  p;
      logic [1:0]  dv;
      src_type     src;
      logic [1:0]  adiv;
      logic [1:0]  prediv;
      logic [1:0]  pdiv;
   } pipe_type;

   // x / (d + 1) for d in 0..3; divide by three through a reciprocal
   function automatic logic [31:0] div_small(input logic [31:0] x, input logic [1:0] d);
      logic [63:0] prod;
      logic [31:0] q;
      begin
         prod = {32'd0, x} * RECIP3;
         case (d)
            2'd0: q = x;
            2'd1: q = {1'b0, x[31:1]};
            2'd2: q = {1'b0, prod[63:33]};
            2'd3: q = {2'b0, x[31:2]};
            default: q = x;
         endcase
         return q;
      end
   endfunction

endpackage

FILE: rtl/core/ctfr_cell.sv
module ctfr_cell
   import ctfr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  pipe_type in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output pipe_type out_data
);

   logic     valid_ff;
   logic     valid_in;
   pipe_type data_ff;

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= in_data;
      end
   end

endmodule

FILE: rtl/core/clock_tree_frequency_readback.sv
// channel   | ports                                          | dir
// request   | req_valid req_ready req_*_word                 | in
// response  | rsp_valid rsp_ready rsp_cpu/periph/ahb/apb_hz  | out
//
// Five pipeline cells; a request passes through each cell in turn to the response port.
// One request is taken per cycle unless stalled; each cell carries a 32x32 reciprocal
// multiply at most. A cell frees itself as soon as its neighbor takes its content, so
// bubbles close up. Synchronous reset clears all cell valid bits; payload is not reset.
module clock_tree_frequency_readback
   import ctfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_cpu_pll_word,
   input  logic [31:0] req_periph_pll_word,
   input  logic [31:0] req_bus_cfg_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_cpu_hz,
   output logic [29:0] rsp_periph_hz,
   output logic [31:0] rsp_ahb_hz,
   output logic [30:0] rsp_apb_hz
);

`include "clock_tree_frequency_readback_assert.svh"

   pipe_type            cin  [NCELLS];
   pipe_type            cout [NCELLS];
   logic [NCELLS-1:0]   vin;
   logic [NCELLS-1:0]   rin;
   logic [NCELLS-1:0]   vout;
   logic [NCELLS-1:0]   rout;
   logic [31:0]         ahb_src;
   logic [31:0]         ahb;

   for (genvar i = 0; i < NCELLS; i++) begin : g_cell
      ctfr_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (vin[i]),
         .in_ready  (rin[i]),
         .in_data   (cin[i]),
         .out_valid (vout[i]),
         .out_ready (rout[i]),
         .out_data  (cout[i])
      );
      if (i > 0) begin : g_link
         assign vin[i]    = vout[i-1];
         assign rout[i-1] = rin[i];
      end
   end

   assign vin[0]           = req_valid;
   assign req_ready        = rin[0];
   assign rout[NCELLS-1]   = rsp_ready;
   assign rsp_valid        = vout[NCELLS-1];

   // decode and scale by n+1, mul+1
   always_comb begin
      cin[0]         = '0;
      cin[0].cpu     = {2'b0, 30'(XTAL_HZ * ({1'b0, req_cpu_pll_word[12:8]} + 6'd1))};
      cin[0].per     = 30'(XTAL_HZ * ({1'b0, req_periph_pll_word[12:8]} + 6'd1));
      cin[0].kp1     = {1'b0, req_cpu_pll_word[5:4]} + 3'd1;
      cin[0].m       = req_cpu_pll_word[1:0];
      cin[0].p       = req_cpu_pll_word[17:16];
      cin[0].dv      = req_periph_pll_word[5:4];
      cin[0].adiv    = req_bus_cfg_word[5:4];
      cin[0].prediv  = req_bus_cfg_word[7:6];
      cin[0].pdiv    = req_bus_cfg_word[9:8];
      cin[0].src     = src_type'(req_bus_cfg_word[13:12]);
   end

   // scale by k+1, divide periph by div+1
   always_comb begin
      cin[1]     = cout[0];
      cin[1].cpu = 32'(cout[0].cpu[29:0] * cout[0].kp1);
      cin[1].per = 30'(div_small({2'b0, cout[0].per}, cout[0].dv));
   end

   // divide cpu by m+1
   always_comb begin
      cin[2]     = cout[1];
      cin[2].cpu = div_small(cout[1].cpu, cout[1].m);
   end

   // apply 2^p, prescale periph for the bus
   always_comb begin
      cin[3]         = cout[2];
      cin[3].cpu     = cout[2].cpu >> cout[2].p;
      cin[3].per_pre = 30'(div_small({2'b0, cout[2].per}, cout[2].prediv));
   end

   // select bus source, divide for ahb and apb
   always_comb begin
      case (cout[3].src)
         SRC_LOSC:   ahb_src = {17'd0, LOSC_HZ};
         SRC_XTAL:   ahb_src = {7'd0, XTAL_HZ};
         SRC_CPU:    ahb_src = cout[3].cpu;
         SRC_PERIPH: ahb_src = {2'b0, cout[3].per_pre};
         default:    ahb_src = cout[3].cpu;
      endcase
      ahb    = ahb_src >> cout[3].adiv;
      cin[4] = cout[3];
      cin[4].per_pre = ahb[29:0];
      cin[4].kp1     = {1'b0, ahb[31:30]};
      case (cout[3].pdiv)
         2'd2:    cin[4].apb = ahb >> 2;
         2'd3:    cin[4].apb = ahb >> 3;
         default: cin[4].apb = ahb >> 1;
      endcase
   end

   assign rsp_cpu_hz    = cout[NCELLS-1].cpu;
   assign rsp_periph_hz = cout[NCELLS-1].per;
   assign rsp_ahb_hz    = {cout[NCELLS-1].kp1[1:0], cout[NCELLS-1].per_pre};
   assign rsp_apb_hz    = cout[NCELLS-1].apb[30:0];

   `CTFR_ASSERT_NOW(a_apb_le_ahb, clock, reset, rsp_valid, rsp_apb_hz <= rsp_ahb_hz[31:1])
   `CTFR_ASSERT_NOW(a_stall_full, clock, reset, !req_ready, &vout)
   `CTFR_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid && vout == '0)

endmodule
